FILE: rtl/core/ffba_pkg.sv
package ffba_pkg;

	// Default table depth and fixed header size in bytes
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int HEADER_BYTES   = 16;

	// Register reset values
	localparam logic [31:0] HEAP_BASE_RST  = 32'd65536;
	localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;

	// Configuration register indexes
	localparam int          CFG_IDX_W      = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

	// Request operations
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Result status codes
	localparam logic [2:0] STS_REUSED   = 3'd0;
	localparam logic [2:0] STS_APPENDED = 3'd1;
	localparam logic [2:0] STS_FAILED   = 3'd2;
	localparam logic [2:0] STS_FREED    = 3'd3;
	localparam logic [2:0] STS_TRIMMED  = 3'd4;
	localparam logic [2:0] STS_IGNORED  = 3'd5;

	typedef struct packed {
		logic        func;
		logic [31:0] req_size;
		logic [31:0] payload_addr;
	} req_item_t;

	typedef struct packed {
		logic [31:0] result_addr;
		logic [2:0]  status;
	} rsp_item_t;

	// One row of the block table
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
		logic        freed;
	} blk_entry_t;

endpackage

FILE: rtl/core/first_fit_block_allocator_top.sv
// First-fit heap block allocator: table of blocks in a one-port-read memory.
// One item at a time; null requests skip the table, others scan it from the
// first row, one memory read per entry per cycle, and an allocate that finds
// no fit appends a row at the end.
// Reset clears the block count, restores heap_limit and puts the break at the
// heap_base reset value; table rows hold no reset value, only read below the count.
module first_fit_block_allocator_top #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ffba_pkg::req_item_t            req_item,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output ffba_pkg::rsp_item_t            rsp_item,
	input  logic                           cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                    cfg_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);

	logic                 res_valid;
	logic                 res_take;
	ffba_pkg::rsp_item_t  res_item;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wr_addr;
	ffba_pkg::blk_entry_t mem_wr_data;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_rd_addr;
	ffba_pkg::blk_entry_t mem_rd_data;
	logic                 rsp_valid_q;
	ffba_pkg::rsp_item_t  rsp_item_q;

	ffba_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_item   (req_item),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.res_valid  (res_valid),
		.res_item   (res_item),
		.res_take   (res_take),
		.mem_we     (mem_we),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_re     (mem_re),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	ffba_mem #(
		.DEPTH(MAX_BLOCKS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_re),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// Output register: takes a finished item when empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_item_q <= res_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

`ifndef ASSERT_OFF
	// A finished result is never pending while a new request can enter
	a_res_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> req_stall)
		else $error("result pending while request side open");

	// Table writes only happen inside a request
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> req_stall)
		else $error("table write while idle");

	// Handing a result over returns the sequencer to idle
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> !req_stall && !res_valid)
		else $error("sequencer not idle after result handover");

	// Never a table read and a write to the same row in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wr_addr != mem_rd_addr))
		else $error("read and write of the same table row");
`endif

endmodule

FILE: rtl/core/ffba_mem.sv
module ffba_mem #(
	parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  ffba_pkg::blk_entry_t  wr_data,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output ffba_pkg::blk_entry_t  rd_data
);

	ffba_pkg::blk_entry_t mem_q [DEPTH];
	ffba_pkg::blk_entry_t rd_data_q;

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/ffba_ctrl.sv
module ffba_ctrl #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int IDX_W      = $clog2(MAX_BLOCKS),
	parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request side
	input  logic                           req_valid,
	output logic                           req_stall,
	input  ffba_pkg::req_item_t            req_item,
	// configuration
	input  logic                           cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                    cfg_data,
	// finished result towards the output register
	output logic                           res_valid,
	output ffba_pkg::rsp_item_t            res_item,
	input  logic                           res_take,
	// table memory
	output logic                           mem_we,
	output logic [IDX_W-1:0]               mem_wr_addr,
	output ffba_pkg::blk_entry_t           mem_wr_data,
	output logic                           mem_re,
	output logic [IDX_W-1:0]               mem_rd_addr,
	input  ffba_pkg::blk_entry_t           mem_rd_data
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_APPEND = 2'd2;
	localparam logic [1:0] S_RESP   = 2'd3;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [1:0]       state_q;
	logic             func_q;
	logic [31:0]      size_q;
	logic [31:0]      paddr_q;
	logic [31:0]      heap_limit_q;
	logic [31:0]      break_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] idx_s1;
	logic             vld_s1;
	logic [31:0]      res_addr_q;
	logic [2:0]       res_status_q;

	logic [CNT_W-1:0] last_idx;
	logic [32:0]      ent_pay;
	logic             fit;
	logic             addr_hit;
	logic             hit;
	logic             miss;
	logic [33:0]      new_brk;
	logic             full;
	logic             over;
	logic             accept;
	logic             trivial;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res_item  = '{result_addr: res_addr_q, status: res_status_q};

	// Zero-size allocate and null free need no table access
	assign trivial = (req_item.func == ffba_pkg::FUNC_ALLOC) ? (req_item.req_size == '0)
	                                                         : (req_item.payload_addr == '0);

	// Compare stage on the entry whose read was issued in the previous cycle
	assign last_idx = count_q - CNT_ONE;
	assign ent_pay  = {1'b0, mem_rd_data.base} + 33'(ffba_pkg::HEADER_BYTES);
	assign fit      = mem_rd_data.freed && (mem_rd_data.size >= size_q);
	assign addr_hit = (ent_pay == {1'b0, paddr_q});
	assign hit      = vld_s1 && ((func_q == ffba_pkg::FUNC_ALLOC) ? fit : addr_hit);
	assign miss     = vld_s1 && !hit && (idx_s1 == last_idx);

	// Read issue: one entry per cycle until a hit or the last entry
	assign mem_re      = (state_q == S_SCAN) && (iss_q < count_q) && !hit && !miss;
	assign mem_rd_addr = iss_q[IDX_W-1:0];

	// Append check, computed without wrap
	assign new_brk = {2'b0, break_q} + 34'(ffba_pkg::HEADER_BYTES) + {2'b0, size_q};
	assign full    = (count_q == CNT_FULL);
	assign over    = (new_brk > {2'b0, heap_limit_q});

	// Write-back: on a hit set the freed flag to match the request, or add a row at the end
	always_comb begin
		mem_we      = 1'b0;
		mem_wr_addr = idx_s1[IDX_W-1:0];
		mem_wr_data = '{base: mem_rd_data.base, size: mem_rd_data.size,
		                freed: (func_q == ffba_pkg::FUNC_FREE)};
		if (state_q == S_SCAN && hit) begin
			mem_we = 1'b1;
		end else if (state_q == S_APPEND && !full && !over) begin
			mem_we      = 1'b1;
			mem_wr_addr = count_q[IDX_W-1:0];
			mem_wr_data = '{base: break_q, size: size_q, freed: 1'b0};
		end
	end

	// Request payload and result, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req_item.func;
			size_q  <= req_item.req_size;
			paddr_q <= req_item.payload_addr;
			if (trivial) begin
				res_addr_q   <= '0;
				res_status_q <= (req_item.func == ffba_pkg::FUNC_ALLOC) ? ffba_pkg::STS_FAILED
				                                                        : ffba_pkg::STS_IGNORED;
			end else if (count_q == '0) begin
				res_addr_q   <= '0;
				res_status_q <= ffba_pkg::STS_IGNORED;
			end
		end
		if (state_q == S_SCAN) begin
			if (hit) begin
				if (func_q == ffba_pkg::FUNC_ALLOC) begin
					res_addr_q   <= ent_pay[31:0];
					res_status_q <= ffba_pkg::STS_REUSED;
				end else begin
					res_addr_q <= '0;
					if (mem_rd_data.freed) begin
						res_status_q <= ffba_pkg::STS_IGNORED;
					end else if (idx_s1 == last_idx) begin
						res_status_q <= ffba_pkg::STS_TRIMMED;
					end else begin
						res_status_q <= ffba_pkg::STS_FREED;
					end
				end
			end else if (miss) begin
				res_addr_q   <= '0;
				res_status_q <= ffba_pkg::STS_IGNORED;
			end
		end
		if (state_q == S_APPEND) begin
			if (full || over) begin
				res_addr_q   <= '0;
				res_status_q <= ffba_pkg::STS_FAILED;
			end else begin
				res_addr_q   <= break_q + 32'(ffba_pkg::HEADER_BYTES);
				res_status_q <= ffba_pkg::STS_APPENDED;
			end
		end
		idx_s1 <= iss_q;
	end

	// Sequencer, table count, break pointer and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			iss_q        <= '0;
			vld_s1       <= 1'b0;
			count_q      <= '0;
			break_q      <= ffba_pkg::HEAP_BASE_RST;
			heap_limit_q <= ffba_pkg::HEAP_LIMIT_RST;
		end else begin
			vld_s1 <= mem_re;
			if (mem_re) begin
				iss_q <= iss_q + CNT_ONE;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_q <= '0;
						if (trivial) begin
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= (req_item.func == ffba_pkg::FUNC_ALLOC) ? S_APPEND
							                                                   : S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_RESP;
						if (func_q == ffba_pkg::FUNC_FREE && !mem_rd_data.freed &&
						    idx_s1 == last_idx) begin
							break_q <= mem_rd_data.base;
							count_q <= last_idx;
						end
					end else if (miss) begin
						state_q <= (func_q == ffba_pkg::FUNC_ALLOC) ? S_APPEND : S_RESP;
					end
				end
				S_APPEND: begin
					state_q <= S_RESP;
					if (!full && !over) begin
						count_q <= count_q + CNT_ONE;
						break_q <= new_brk[31:0];
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// the user must write registers only while idle, which the block does not enforce;
			// heap_base only matters through the break, which it moves while the table is empty
			if (cfg_we) begin
				unique case (cfg_idx)
					ffba_pkg::CFG_HEAP_BASE: begin
						if (count_q == '0) begin
							break_q <= cfg_data;
						end
					end
					ffba_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: test/tb_first_fit_block_allocator_top.sv
module tb_first_fit_block_allocator_top;
	import ffba_pkg::*;

	localparam int TBL_DEPTH    = MAX_BLOCKS_DEF;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 500;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_item_t            req_item  = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_item_t            rsp_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = CFG_HEAP_BASE;
	logic [31:0]          cfg_data  = '0;

	// shadow of the allocator: registers, block table, break
	logic [31:0] mdl_heap_base  = HEAP_BASE_RST;
	logic [31:0] mdl_heap_limit = HEAP_LIMIT_RST;
	logic [31:0] mdl_base [TBL_DEPTH];
	logic [31:0] mdl_size [TBL_DEPTH];
	logic        mdl_freed [TBL_DEPTH];
	int          mdl_count = 0;
	logic [31:0] mdl_break = HEAP_BASE_RST;

	req_item_t   req_backlog [$];
	rsp_item_t   heap_outcomes [$];
	logic [31:0] live_payloads [$];

	int   pushed_count = 0;
	int   results_seen = 0;
	int   fail_count   = 0;
	int   cycle_count  = 0;
	logic req_taken    = 1'b0;

	// sender burst shaping
	int burst_left = 0;
	int gap_left   = 0;

	// receiver stall pattern and the one long hold-off
	int   stall_mode = 0;
	int   mode_left  = 0;
	int   hold_left  = 0;
	logic hold_done  = 1'b0;

	first_fit_block_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// First-fit prediction for one accepted request; updates the shadow state
	function automatic rsp_item_t heap_predict(input req_item_t r);
		rsp_item_t   o;
		logic [33:0] grown;
		int          hit;
		o.result_addr = '0;
		o.status      = STS_FAILED;
		hit           = -1;
		if (r.func == FUNC_ALLOC) begin
			if (r.req_size != '0) begin
				for (int i = 0; i < mdl_count; i++)
					if (hit < 0 && mdl_freed[i] && mdl_size[i] >= r.req_size)
						hit = i;
				if (hit >= 0) begin
					// reuse whole block, no split
					mdl_freed[hit] = 1'b0;
					o.result_addr  = mdl_base[hit] + 32'(HEADER_BYTES);
					o.status       = STS_REUSED;
				end else if (mdl_count < TBL_DEPTH) begin
					// growth is checked without wrap
					grown = 34'(mdl_break) + 34'(HEADER_BYTES) + 34'(r.req_size);
					if (grown <= 34'(mdl_heap_limit)) begin
						mdl_base[mdl_count]  = mdl_break;
						mdl_size[mdl_count]  = r.req_size;
						mdl_freed[mdl_count] = 1'b0;
						mdl_count++;
						o.result_addr = mdl_break + 32'(HEADER_BYTES);
						o.status      = STS_APPENDED;
						mdl_break     = grown[31:0];
					end
				end
			end
		end else begin
			o.status = STS_IGNORED;
			if (r.payload_addr != '0) begin
				for (int i = 0; i < mdl_count; i++)
					if (hit < 0 && 33'(mdl_base[i]) + 33'(HEADER_BYTES) == 33'(r.payload_addr))
						hit = i;
				if (hit >= 0 && !mdl_freed[hit]) begin
					mdl_freed[hit] = 1'b1;
					if (hit == mdl_count - 1) begin
						// last block goes, break falls back to its header
						mdl_break = mdl_base[hit];
						mdl_count--;
						o.status  = STS_TRIMMED;
					end else begin
						o.status = STS_FREED;
					end
				end
			end
		end
		if (o.status == STS_REUSED || o.status == STS_APPENDED) begin
			live_payloads.push_back(o.result_addr);
			if (live_payloads.size() > 200)
				void'(live_payloads.pop_front());
		end
		return o;
	endfunction

	// Random request: mostly small sizes and frees of live payloads, plus noise
	function automatic req_item_t random_request(input int alloc_pct);
		req_item_t r;
		int        pick;
		int        idx;
		r.func         = FUNC_ALLOC;
		r.req_size     = $urandom;
		r.payload_addr = $urandom;
		pick           = $urandom_range(99);
		if ($urandom_range(99) < alloc_pct) begin
			if (pick < 5)
				r.req_size = '0;
			else if (pick < 70)
				r.req_size = $urandom_range(64, 1);
			else if (pick < 88)
				r.req_size = $urandom_range(4096, 65);
			else if (pick < 93)
				r.req_size = 32'hFFFF_FFFF;
		end else begin
			r.func = FUNC_FREE;
			if (pick < 8) begin
				r.payload_addr = '0;
			end else if (pick < 16 || live_payloads.size() == 0) begin
				// keep the random address
			end else if (pick < 40) begin
				// most recent allocation: likely a trim
				r.payload_addr = live_payloads.pop_back();
			end else if (pick < 48) begin
				idx = $urandom_range(live_payloads.size() - 1);
				r.payload_addr = live_payloads[idx] + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
			end else begin
				idx = $urandom_range(live_payloads.size() - 1);
				r.payload_addr = live_payloads[idx];
				if ($urandom_range(99) < 85)
					live_payloads.delete(idx);
			end
		end
		return r;
	endfunction

	task automatic push_req(input logic f, input logic [31:0] sz, input logic [31:0] pa);
		req_item_t r;
		r.func         = f;
		r.req_size     = sz;
		r.payload_addr = pa;
		while (req_backlog.size() >= 2)
			@(negedge clk);
		req_backlog.push_back(r);
		pushed_count++;
	endtask

	task automatic random_phase(input int n, input int alloc_pct);
		req_item_t r;
		for (int k = 0; k < n; k++) begin
			r = random_request(alloc_pct);
			push_req(r.func, r.req_size, r.payload_addr);
		end
	endtask

	// every pushed request answered, then a short quiet spell
	task automatic wait_drained();
		while (results_seen != pushed_count)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write while the block is idle; shadow follows
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HEAP_BASE) begin
			mdl_heap_base = val;
			if (mdl_count == 0)
				mdl_break = val;
		end else if (idx == CFG_HEAP_LIMIT) begin
			mdl_heap_limit = val;
		end
	endtask

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", what);
	endtask

	// request driver: bursts with random gaps, payload held while stalled
	always @(negedge clk) begin : req_driver
		logic      nxt_valid;
		req_item_t nxt_item;
		nxt_valid = req_valid;
		nxt_item  = req_item;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!req_valid || req_taken) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (req_backlog.size() > 0) begin
				nxt_item  = req_backlog.pop_front();
				nxt_valid = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(24, 1);
					gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
				end
			end
		end
		req_valid <= nxt_valid;
		req_item  <= nxt_item;
	end

	// response stall: changing patterns, plus one long hold-off to back up the input
	always @(negedge clk) begin : rsp_staller
		logic nxt_stall;
		nxt_stall = 1'b0;
		if (!arst_n) begin
			nxt_stall = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			nxt_stall = 1'b1;
		end else if (!hold_done && results_seen >= 300) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			nxt_stall = 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(3);
				mode_left  = $urandom_range(256, 32);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: nxt_stall = 1'b0;
				1: nxt_stall = ($urandom_range(99) < 30);
				2: nxt_stall = ($urandom_range(99) < 75);
				default: nxt_stall = ~rsp_stall;
			endcase
		end
		rsp_stall <= nxt_stall;
	end

	// accepted requests feed the predictor; accepted results are checked in order
	always @(posedge clk) begin : rsp_monitor
		rsp_item_t want;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall)
			heap_outcomes.push_back(heap_predict(req_item));
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (heap_outcomes.size() == 0) begin
				note_failure($sformatf("unexpected result: addr %h status %0d",
					rsp_item.result_addr, rsp_item.status));
			end else begin
				want = heap_outcomes.pop_front();
				if (rsp_item.result_addr !== want.result_addr || rsp_item.status !== want.status)
					note_failure($sformatf(
						"mismatch on result %0d: addr exp %h got %h, status exp %0d got %0d",
						results_seen, want.result_addr, rsp_item.result_addr,
						want.status, rsp_item.status));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("first_fit_block_allocator_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, zero base and limit: everything fails or is ignored
		write_reg(CFG_HEAP_BASE, 32'h0000_0000);
		write_reg(CFG_HEAP_LIMIT, 32'h0000_0000);
		push_req(FUNC_ALLOC, 32'd0, 32'h0);
		push_req(FUNC_ALLOC, 32'd1, 32'h0);
		push_req(FUNC_FREE, 32'hFFFF_FFFF, 32'h0);
		push_req(FUNC_FREE, 32'h0, 32'hFFFF_FFFF);
		wait_drained();

		// break at the top of the address space: growth overflows the limit
		write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
		write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
		push_req(FUNC_ALLOC, 32'd1, 32'h0);
		push_req(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h0);
		wait_drained();

		// small heap at 0x1000: append, reuse, double free, trims down to empty
		write_reg(CFG_HEAP_BASE, 32'h0000_1000);
		write_reg(CFG_HEAP_LIMIT, HEAP_LIMIT_RST);
		push_req(FUNC_ALLOC, 32'd1, 32'h0);
		push_req(FUNC_ALLOC, 32'd100, 32'h0);
		push_req(FUNC_ALLOC, 32'd8, 32'h0);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1010);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1010);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1011);
		push_req(FUNC_ALLOC, 32'd2, 32'h0);
		push_req(FUNC_ALLOC, 32'd1, 32'h0);
		push_req(FUNC_FREE, 32'h0, 32'h0000_10AD);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1095);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1021);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1010);
		// a freed block left behind a trim stays in the table
		push_req(FUNC_ALLOC, 32'd4, 32'h0);
		push_req(FUNC_ALLOC, 32'd4, 32'h0);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1010);
		push_req(FUNC_FREE, 32'h0, 32'h0000_1024);
		push_req(FUNC_ALLOC, 32'd5, 32'h0);
		wait_drained();

		// base written with blocks live: break unchanged, the write has no effect
		write_reg(CFG_HEAP_BASE, 32'h0002_0000);
		random_phase(300, 70);
		wait_drained();

		// tight limit
		write_reg(CFG_HEAP_LIMIT, 32'h0000_2000);
		random_phase(200, 55);
		wait_drained();

		// widest limit, free-heavy
		write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
		random_phase(250, 40);
		wait_drained();

		// no growth at all: reuse only
		write_reg(CFG_HEAP_LIMIT, 32'h0000_0000);
		random_phase(100, 50);
		wait_drained();

		write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_HEAP_LIMIT, HEAP_LIMIT_RST);
		random_phase(330, 60);
		wait_drained();

		repeat (80) @(negedge clk);
		if (heap_outcomes.size() != 0)
			note_failure($sformatf("%0d results never arrived", heap_outcomes.size()));
		if (fail_count == 0) begin
			$display("first_fit_block_allocator_top regression: pass");
		end else begin
			$display("first_fit_block_allocator_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_mem.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_top.sv
test/tb_first_fit_block_allocator_top.sv
